/* rtl/grouped_team_queue_core_macros.svh */
// Assertion macros shared by the grouped team queue RTL.
// Depends on nothing; included inside module bodies.
`ifndef GROUPED_TEAM_QUEUE_CORE_MACROS_SVH
`define GROUPED_TEAM_QUEUE_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define GTQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication checked outside reset.
`define GTQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* rtl/gtq_pkg.sv */
// Shared types and codes for the grouped team queue.
// No dependencies.
package gtq_pkg;

    typedef enum logic [1:0] {
        CMD_ASSIGN  = 2'd0,
        CMD_ENQUEUE = 2'd1,
        CMD_DEQUEUE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_RESERVED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_EXEC,
        FSM_OUT
    } fsm_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear_step;   // write one membership entry to team zero
        logic capture;      // latch input item, issue memory reads
        logic execute;      // apply read-modify-write, form result
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic clear_done;
    } dp_status_t;

endpackage

/* rtl/gtq_ctrl.sv */
// Controller state machine for the grouped team queue.
// Depends on gtq_pkg.
module gtq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output gtq_pkg::dp_cmd_t    cmd,
    input  gtq_pkg::dp_status_t stat
);
    import gtq_pkg::*;

    fsm_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_CLEAR: if (stat.clear_done) state_next = FSM_IDLE;
            FSM_IDLE:  if (in_valid) state_next = FSM_EXEC;
            FSM_EXEC:  state_next = FSM_OUT;
            FSM_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = in_valid ? FSM_EXEC : FSM_IDLE;
                end
            end
            default:   state_next = FSM_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            FSM_CLEAR: cmd.clear_step = 1'b1;
            FSM_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            FSM_EXEC:  cmd.execute = 1'b1;
            FSM_OUT:
            begin
                out_valid   = 1'b1;
                in_stall    = out_stall;
                cmd.capture = in_valid && !out_stall;
            end
            default: ;
        endcase
    end

    `include "grouped_team_queue_core_macros.svh"
    `GTQ_ASSERT_IMP(a_no_accept_busy, (state_reg == FSM_EXEC), in_stall)
    `GTQ_ASSERT_NEXT(a_exec_then_out, (state_reg == FSM_EXEC), out_valid)
    `GTQ_ASSERT_IMP(a_capture_on_accept, (in_valid && !in_stall), cmd.capture)
endmodule

/* rtl/gtq_datapath.sv */
// Datapath of the grouped team queue: memories, free stack, team ring.
// Depends on gtq_pkg.
module gtq_datapath #(
    parameter int ELEMENT_SPACE = 1024,
    parameter int TEAM_COUNT    = 16,
    parameter int CAPACITY      = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gtq_pkg::dp_cmd_t    cmd,
    output gtq_pkg::dp_status_t stat,
    input  logic [1:0]          command,
    input  logic [9:0]          element,
    input  logic [3:0]          team,
    output logic [9:0]          dequeued_element,
    output logic [1:0]          status
);
    import gtq_pkg::*;

    localparam int EW = (ELEMENT_SPACE > 1) ? $clog2(ELEMENT_SPACE) : 1;
    localparam int TW = (TEAM_COUNT > 1) ? $clog2(TEAM_COUNT) : 1;
    localparam int NW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int OW = $clog2(TEAM_COUNT + 1);

    // Memories
    logic [TW-1:0] membership_mem [ELEMENT_SPACE];
    logic [EW-1:0] node_value_mem [CAPACITY];
    logic [NW-1:0] node_link_mem  [CAPACITY];
    logic [NW-1:0] free_mem       [CAPACITY];
    logic [NW-1:0] team_head_mem  [TEAM_COUNT];
    logic [NW-1:0] team_tail_mem  [TEAM_COUNT];
    logic [TW-1:0] order_mem      [TEAM_COUNT];
    logic [TEAM_COUNT-1:0] waiting_reg;

    logic [CW-1:0] free_count_reg;
    logic [TW-1:0] front_reg, back_reg;
    logic [OW-1:0] order_count_reg;
    logic [EW-1:0] clr_reg;
    logic          clr_done_reg;
    // Lowest free count seen; stack entries below it were never written
    // and read as their own index
    logic [CW-1:0] free_fill_reg;

    // Captured item and registered reads
    cmd_t          cmd_reg;
    logic [EW-1:0] elem_reg;
    logic [TW-1:0] memb_rd_reg;
    logic [NW-1:0] free_rd_reg;
    logic [TW-1:0] front_team_reg;
    logic [9:0]    dq_reg;
    logic [1:0]    st_reg;

    logic [EW-1:0] e_in;
    logic [TW-1:0] t_in;
    logic [NW-1:0] free_top_idx;
    logic          free_top_filled;

    assign e_in = EW'(element);
    assign t_in = TW'(team);
    assign free_top_idx = NW'(free_count_reg - CW'(1));
    assign free_top_filled = (free_count_reg > free_fill_reg);
    assign stat.clear_done = clr_done_reg;
    assign dequeued_element = dq_reg;
    assign status = st_reg;

    // Membership clearing sweep and writes
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            membership_mem[clr_reg] <= '0;
        end
        else if (cmd.capture && cmd_t'(command) == CMD_ASSIGN)
        begin
            membership_mem[e_in] <= t_in;
        end
        if (cmd.capture)
        begin
            memb_rd_reg <= membership_mem[e_in];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (cmd.clear_step)
        begin
            clr_reg <= clr_reg + EW'(1);
            if (clr_reg == EW'(ELEMENT_SPACE - 1))
            begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    // Capture stage: latch item, read free stack top and front team
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg        <= cmd_t'(command);
            elem_reg       <= e_in;
            free_rd_reg    <= free_top_filled ? free_mem[free_top_idx] : free_top_idx;
            front_team_reg <= order_mem[front_reg];
        end
    end

    // Execute stage
    logic [TW-1:0] et;
    logic [NW-1:0] n_new, dq_node, dq_tail;
    assign et      = memb_rd_reg;
    assign n_new   = free_rd_reg;
    assign dq_node = team_head_mem[front_team_reg];
    assign dq_tail = team_tail_mem[front_team_reg];

    logic do_enq, do_deq;
    assign do_enq = cmd.execute && cmd_reg == CMD_ENQUEUE && free_count_reg != '0;
    assign do_deq = cmd.execute && cmd_reg == CMD_DEQUEUE && order_count_reg != '0;

    always_ff @(posedge clk)
    begin
        if (do_enq)
        begin
            node_value_mem[n_new] <= elem_reg;
            if (waiting_reg[et])
            begin
                node_link_mem[team_tail_mem[et]] <= n_new;
                team_tail_mem[et] <= n_new;
            end
            else
            begin
                team_head_mem[et] <= n_new;
                team_tail_mem[et] <= n_new;
                order_mem[back_reg] <= et;
            end
        end
        if (do_deq)
        begin
            free_mem[NW'(free_count_reg)] <= dq_node;
            if (dq_node != dq_tail)
            begin
                team_head_mem[front_team_reg] <= node_link_mem[dq_node];
            end
        end
        if (cmd.execute)
        begin
            dq_reg <= do_deq ? 10'(node_value_mem[dq_node]) : '0;
            priority if (cmd_reg == CMD_ENQUEUE && free_count_reg == '0)
                st_reg <= ST_FULL;
            else if (cmd_reg == CMD_DEQUEUE && order_count_reg == '0)
                st_reg <= ST_EMPTY;
            else
                st_reg <= ST_OK;
        end
    end

    // Control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg  <= CW'(CAPACITY);
            free_fill_reg   <= CW'(CAPACITY);
            front_reg       <= '0;
            back_reg        <= '0;
            order_count_reg <= '0;
            waiting_reg     <= '0;
        end
        else
        begin
            if (do_enq)
            begin
                free_count_reg <= free_count_reg - CW'(1);
                if (!waiting_reg[et])
                begin
                    waiting_reg[et] <= 1'b1;
                    back_reg <= (back_reg == TW'(TEAM_COUNT - 1)) ? '0 : back_reg + TW'(1);
                    order_count_reg <= order_count_reg + OW'(1);
                end
            end
            if (do_deq)
            begin
                free_count_reg <= free_count_reg + CW'(1);
                if (dq_node == dq_tail)
                begin
                    waiting_reg[front_team_reg] <= 1'b0;
                    front_reg <= (front_reg == TW'(TEAM_COUNT - 1)) ? '0 : front_reg + TW'(1);
                    order_count_reg <= order_count_reg - OW'(1);
                end
            end
            if (do_enq && free_fill_reg > free_count_reg - CW'(1))
            begin
                free_fill_reg <= free_count_reg - CW'(1);
            end
        end
    end

    `include "grouped_team_queue_core_macros.svh"
    `GTQ_ASSERT_IMP(a_free_bound, 1'b1, free_count_reg <= CW'(CAPACITY))
    `GTQ_ASSERT_IMP(a_order_bound, 1'b1, order_count_reg <= OW'(TEAM_COUNT))
    `GTQ_ASSERT_IMP(a_waiting_count, 1'b1, $countones(waiting_reg) == int'(order_count_reg))
endmodule

/* rtl/grouped_team_queue_core.sv */
// Grouped team queue: one item in, one result out. Each item is captured with
// its memory reads, then gets a read-modify-write of node and team tables; while
// its result is presented and not stalled, the next item can be captured. After
// reset a sweep sets every element's team to zero, and no item is accepted until
// it ends. Storage holds CAPACITY nodes across up to TEAM_COUNT teams.
module grouped_team_queue_core #(
    parameter int ELEMENT_SPACE = 1024,
    parameter int TEAM_COUNT    = 16,
    parameter int CAPACITY      = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [9:0] element,
    input  logic [3:0] team,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [9:0] dequeued_element,
    output logic [1:0] status
);
    import gtq_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    gtq_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
        .cmd, .stat
    );

    gtq_datapath #(
        .ELEMENT_SPACE(ELEMENT_SPACE),
        .TEAM_COUNT(TEAM_COUNT),
        .CAPACITY(CAPACITY)
    ) u_dp (
        .clk, .rst_n, .cmd, .stat, .command, .element, .team,
        .dequeued_element, .status
    );
endmodule
